/* rtl/lie_pkg.sv */
// Shared types, constants and codes for the Lagrange interpolation evaluator.
package lie_pkg;

  localparam int DEF_MAX_POINTS = 64;

  localparam int COORD_W  = 10;
  localparam int FRAC_W   = 16;
  localparam int VAL_W    = 48;
  localparam int NUM_W    = COORD_W + 1;
  localparam int PROD_W   = VAL_W + COORD_W;
  localparam int DIV_BITS = 4;
  localparam int DIVD_W   = 60;
  localparam int DIV_STEPS = DIVD_W / DIV_BITS;

  localparam int OPC_W    = 2;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 7;

  localparam logic [OPC_W-1:0] OP_ADD   = 2'd0;
  localparam logic [OPC_W-1:0] OP_EVAL  = 2'd1;
  localparam logic [OPC_W-1:0] OP_CLEAR = 2'd2;
  localparam logic [OPC_W-1:0] OP_NOP   = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DUP   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_SAT   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL  = 3'd4;

  localparam logic signed [VAL_W-1:0] VAL_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [VAL_W-1:0] VAL_MIN = 48'sh8000_0000_0000;
  localparam logic [DIVD_W-1:0] QUOT_LIM = 60'h0000_8000_0000_0000;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } point_t;

  typedef struct packed {
    logic              done;
    logic [DIVD_W-1:0] quot;
  } div_res_t;

endpackage

/* rtl/lie_store.sv */
// Point memory: one write port, two registered read ports.
module lie_store #(
  parameter int MAX_POINTS = lie_pkg::DEF_MAX_POINTS,
  parameter int IDX_W = $clog2(MAX_POINTS)
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [IDX_W-1:0]    waddr_i,
  input  lie_pkg::point_t     wdata_i,
  input  logic [IDX_W-1:0]    raddr_a_i,
  input  logic [IDX_W-1:0]    raddr_b_i,
  output lie_pkg::point_t     rdata_a_o,
  output lie_pkg::point_t     rdata_b_o
);

  lie_pkg::point_t mem_q [MAX_POINTS];
  lie_pkg::point_t rd_a_q;
  lie_pkg::point_t rd_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rd_a_q <= mem_q[raddr_a_i];
    rd_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rd_a_q;
  assign rdata_b_o = rd_b_q;

endmodule

/* rtl/lie_div.sv */
// Unsigned radix-16 restoring divider, four quotient bits per cycle.
module lie_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [lie_pkg::DIVD_W-1:0]     dividend_i,
  input  logic [lie_pkg::COORD_W-1:0]    divisor_i,
  output lie_pkg::div_res_t              res_o
);

  localparam int DW  = lie_pkg::DIVD_W;
  localparam int CW  = lie_pkg::COORD_W;
  localparam int SCW = $clog2(lie_pkg::DIV_STEPS + 1);

  logic [DW-1:0]  quot_q, quot_d;
  logic [CW-1:0]  rem_q, rem_d;
  logic [SCW-1:0] cnt_q;
  logic           run_q;
  logic [CW:0]    trial;

  always_comb begin
    rem_d  = rem_q;
    quot_d = quot_q;
    trial  = '0;
    for (int i = 0; i < lie_pkg::DIV_BITS; i++) begin
      trial  = {rem_d, quot_d[DW-1]};
      quot_d = {quot_d[DW-2:0], 1'b0};
      if (trial >= {1'b0, divisor_i}) begin
        trial     = trial - {1'b0, divisor_i};
        quot_d[0] = 1'b1;
      end
      rem_d = trial[CW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      run_q <= 1'b0;
    end else if (start_i) begin
      cnt_q <= SCW'(lie_pkg::DIV_STEPS);
      run_q <= 1'b1;
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 1'b1;
    end else begin
      run_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= dividend_i;
      rem_q  <= '0;
    end else if (cnt_q != '0) begin
      quot_q <= quot_d;
      rem_q  <= rem_d;
    end
  end

  assign res_o.done = run_q && (cnt_q == '0);
  assign res_o.quot = quot_q;

endmodule

/* rtl/lagrange_interpolation_eval.sv */
// Top level of the Lagrange interpolation evaluator.
// Holds up to MAX_POINTS (x, y) points in a dual-read memory and answers one
// opcode per transfer: add, evaluate, clear or no operation, with one result
// each. In an evaluate, each ordered point pair needs a memory read, one
// 48x10 multiply and a 60-bit divide in a shared divider that yields four
// quotient bits per cycle; the pair loop is the limit. A duplicate x ends
// the evaluate at the first equal pair found. The next item is taken as
// soon as the previous result sits in the output register. No clearing
// pass follows reset.
module lagrange_interpolation_eval #(
  parameter int MAX_POINTS = lie_pkg::DEF_MAX_POINTS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [lie_pkg::OPC_W-1:0]           opcode_i,
  input  logic [lie_pkg::COORD_W-1:0]         point_x_i,
  input  logic [lie_pkg::COORD_W-1:0]         point_y_i,
  input  logic [lie_pkg::COORD_W-1:0]         query_x_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [lie_pkg::VAL_W-1:0]    interp_value_o,
  output logic [lie_pkg::STATUS_W-1:0]        status_o,
  output logic [lie_pkg::COUNT_W-1:0]         stored_count_o
);

  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int VW    = lie_pkg::VAL_W;
  localparam int CW    = lie_pkg::COORD_W;
  localparam int PW    = lie_pkg::PROD_W;
  localparam int DW    = lie_pkg::DIVD_W;
  localparam int FW    = lie_pkg::FRAC_W;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_WLD    = 8'b0000_0010,
    S_WINIT  = 8'b0000_0100,
    S_VRD    = 8'b0000_1000,
    S_VCHK   = 8'b0001_0000,
    S_DSTART = 8'b0010_0000,
    S_DWAIT  = 8'b0100_0000,
    S_FIN    = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  logic [CNT_W-1:0]              count_q, count_d;
  logic [CNT_W-1:0]              w_q, w_d;
  logic [CNT_W-1:0]              v_q, v_d;
  logic [CW-1:0]                 qx_q, qx_d;
  logic [CW-1:0]                 xw_q, xw_d;
  logic signed [VW-1:0]          term_q, term_d;
  logic signed [VW-1:0]          sum_q, sum_d;
  logic                          sat_q, sat_d;
  logic [PW-1:0]                 prod_q, prod_d;
  logic                          neg_q, neg_d;
  logic [CW-1:0]                 dsor_q, dsor_d;
  logic signed [VW-1:0]          res_value_q, res_value_d;
  logic [lie_pkg::STATUS_W-1:0]  res_status_q, res_status_d;
  logic                          out_valid_q, out_valid_d;
  logic signed [VW-1:0]          out_value_q, out_value_d;
  logic [lie_pkg::STATUS_W-1:0]  out_status_q, out_status_d;
  logic [lie_pkg::COUNT_W-1:0]   out_count_q, out_count_d;

  logic                          in_xfer;
  logic                          out_free;
  logic                          mem_we;
  lie_pkg::point_t               wdata;
  lie_pkg::point_t               rd_a;
  lie_pkg::point_t               rd_b;
  lie_pkg::div_res_t             div_res;

  logic signed [lie_pkg::NUM_W-1:0] num_s;
  logic signed [lie_pkg::NUM_W-1:0] den_s;
  logic [CW-1:0]                 num_mag;
  logic [CW-1:0]                 den_mag;
  logic [VW-1:0]                 term_mag;
  logic signed [VW:0]            sum_ext;
  logic signed [VW-1:0]          sum_clamp;
  logic                          sum_ovf;
  logic signed [VW-1:0]          quo_clamp;
  logic                          quo_ovf;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign mem_we     = in_xfer && (opcode_i == lie_pkg::OP_ADD) &&
                      (count_q < CNT_W'(MAX_POINTS));
  assign wdata.x    = point_x_i;
  assign wdata.y    = point_y_i;

  lie_store #(
    .MAX_POINTS (MAX_POINTS),
    .IDX_W      (IDX_W)
  ) u_store (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .waddr_i   (count_q[IDX_W-1:0]),
    .wdata_i   (wdata),
    .raddr_a_i (w_q[IDX_W-1:0]),
    .raddr_b_i (v_q[IDX_W-1:0]),
    .rdata_a_o (rd_a),
    .rdata_b_o (rd_b)
  );

  lie_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (state_q == S_DSTART),
    .dividend_i (DW'(prod_q)),
    .divisor_i  (dsor_q),
    .res_o      (div_res)
  );

  assign num_s    = signed'({1'b0, qx_q}) - signed'({1'b0, rd_b.x});
  assign den_s    = signed'({1'b0, xw_q}) - signed'({1'b0, rd_b.x});
  assign num_mag  = num_s[CW] ? CW'(-num_s) : num_s[CW-1:0];
  assign den_mag  = den_s[CW] ? CW'(-den_s) : den_s[CW-1:0];
  assign term_mag = term_q[VW-1] ? VW'(-term_q) : VW'(term_q);

  assign sum_ext   = {sum_q[VW-1], sum_q} + {term_q[VW-1], term_q};
  assign sum_ovf   = (sum_ext[VW] != sum_ext[VW-1]);
  assign sum_clamp = !sum_ovf ? sum_ext[VW-1:0] :
                     (sum_ext[VW] ? lie_pkg::VAL_MIN : lie_pkg::VAL_MAX);

  always_comb begin
    if (neg_q) begin
      quo_ovf   = (div_res.quot > lie_pkg::QUOT_LIM);
      quo_clamp = quo_ovf ? lie_pkg::VAL_MIN : VW'(-div_res.quot[VW-1:0]);
    end else begin
      quo_ovf   = (div_res.quot >= lie_pkg::QUOT_LIM);
      quo_clamp = quo_ovf ? lie_pkg::VAL_MAX : signed'(div_res.quot[VW-1:0]);
    end
  end

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    w_d          = w_q;
    v_d          = v_q;
    qx_d         = qx_q;
    xw_d         = xw_q;
    term_d       = term_q;
    sum_d        = sum_q;
    sat_d        = sat_q;
    prod_d       = prod_q;
    neg_d        = neg_q;
    dsor_d       = dsor_q;
    res_value_d  = res_value_q;
    res_status_d = res_status_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_value_d  = out_value_q;
    out_status_d = out_status_q;
    out_count_d  = out_count_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          res_value_d  = '0;
          res_status_d = lie_pkg::ST_OK;
          state_d      = S_FIN;
          unique case (opcode_i)
            lie_pkg::OP_ADD: begin
              if (mem_we) begin
                count_d = count_q + 1'b1;
              end else begin
                res_status_d = lie_pkg::ST_FULL;
              end
            end
            lie_pkg::OP_EVAL: begin
              if (count_q == '0) begin
                res_status_d = lie_pkg::ST_EMPTY;
              end else begin
                qx_d    = query_x_i;
                w_d     = '0;
                sum_d   = '0;
                sat_d   = 1'b0;
                state_d = S_WLD;
              end
            end
            lie_pkg::OP_CLEAR: begin
              count_d = '0;
            end
            lie_pkg::OP_NOP: begin
              count_d = count_q;
            end
            default: begin
              count_d = count_q;
            end
          endcase
        end
      end
      S_WLD: begin
        state_d = S_WINIT;
      end
      S_WINIT: begin
        term_d  = signed'({{(VW-CW-FW){1'b0}}, rd_a.y, {FW{1'b0}}});
        xw_d    = rd_a.x;
        v_d     = '0;
        state_d = S_VRD;
      end
      S_VRD: begin
        state_d = S_VCHK;
      end
      S_VCHK: begin
        if (v_q == count_q) begin
          sum_d = sum_clamp;
          sat_d = sat_q || sum_ovf;
          if (w_q + 1'b1 == count_q) begin
            res_value_d  = sum_clamp;
            res_status_d = (sat_q || sum_ovf) ? lie_pkg::ST_SAT : lie_pkg::ST_OK;
            state_d      = S_FIN;
          end else begin
            w_d     = w_q + 1'b1;
            state_d = S_WLD;
          end
        end else if (v_q == w_q) begin
          v_d     = v_q + 1'b1;
          state_d = S_VRD;
        end else if (rd_b.x == xw_q) begin
          res_value_d  = '0;
          res_status_d = lie_pkg::ST_DUP;
          state_d      = S_FIN;
        end else begin
          prod_d  = PW'(term_mag) * PW'(num_mag);
          neg_d   = term_q[VW-1] ^ num_s[CW] ^ den_s[CW];
          dsor_d  = den_mag;
          state_d = S_DSTART;
        end
      end
      S_DSTART: begin
        state_d = S_DWAIT;
      end
      S_DWAIT: begin
        if (div_res.done) begin
          term_d  = quo_clamp;
          sat_d   = sat_q || quo_ovf;
          v_d     = v_q + 1'b1;
          state_d = S_VRD;
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_value_d  = res_value_q;
          out_status_d = res_status_q;
          out_count_d  = lie_pkg::COUNT_W'(count_q);
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q          <= w_d;
    v_q          <= v_d;
    qx_q         <= qx_d;
    xw_q         <= xw_d;
    term_q       <= term_d;
    sum_q        <= sum_d;
    sat_q        <= sat_d;
    prod_q       <= prod_d;
    neg_q        <= neg_d;
    dsor_q       <= dsor_d;
    res_value_q  <= res_value_d;
    res_status_q <= res_status_d;
    out_value_q  <= out_value_d;
    out_status_q <= out_status_d;
    out_count_q  <= out_count_d;
  end

  assign out_valid_o    = out_valid_q;
  assign interp_value_o = out_value_q;
  assign status_o       = out_status_q;
  assign stored_count_o = out_count_q;

endmodule

/* rtl/lie_checker.sv */
// Port-level checker for the Lagrange interpolation evaluator, bound to the top.
module lie_checker #(
  parameter int MAX_POINTS = lie_pkg::DEF_MAX_POINTS
) (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_stall_o,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input logic signed [lie_pkg::VAL_W-1:0]    interp_value_o,
  input logic [lie_pkg::STATUS_W-1:0]        status_o,
  input logic [lie_pkg::COUNT_W-1:0]         stored_count_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o))
    else $error("output dropped while stalled");

  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while an item is in flight");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == lie_pkg::ST_EMPTY || status_o == lie_pkg::ST_DUP ||
                    status_o == lie_pkg::ST_FULL)
    |-> interp_value_o == '0)
    else $error("nonzero value with error status");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (MAX_POINTS >= 128) || (int'(stored_count_o) <= MAX_POINTS))
    else $error("stored count beyond capacity");

endmodule

bind lagrange_interpolation_eval lie_checker #(.MAX_POINTS(MAX_POINTS)) u_lie_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .interp_value_o (interp_value_o),
  .status_o       (status_o),
  .stored_count_o (stored_count_o)
);

/* sim/tb.sv */
// Self-checking testbench for the Lagrange interpolation evaluator.
module tb;

  typedef struct {
    logic [lie_pkg::OPC_W-1:0]          op;
    logic [lie_pkg::COORD_W-1:0]        px;
    logic [lie_pkg::COORD_W-1:0]        py;
    logic [lie_pkg::COORD_W-1:0]        qx;
    bit                                 typed;
    logic signed [lie_pkg::VAL_W-1:0]   val;
    logic [lie_pkg::STATUS_W-1:0]       st;
    logic [lie_pkg::COUNT_W-1:0]        cnt;
  } cmd_t;

  typedef struct {
    logic signed [lie_pkg::VAL_W-1:0]   val;
    logic [lie_pkg::STATUS_W-1:0]       st;
    logic [lie_pkg::COUNT_W-1:0]        cnt;
  } answer_t;

  localparam int NPTS = lie_pkg::DEF_MAX_POINTS;
  localparam int CW = lie_pkg::COORD_W;
  localparam longint QMAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint QMIN = -QMAX - 1;

  logic                               clk_i = 1'b0;
  logic                               rst_ni = 1'b0;
  logic                               in_valid_i = 1'b0;
  logic                               in_stall_o;
  logic [lie_pkg::OPC_W-1:0]          opcode_i = lie_pkg::OP_NOP;
  logic [CW-1:0]                      point_x_i = '0;
  logic [CW-1:0]                      point_y_i = '0;
  logic [CW-1:0]                      query_x_i = '0;
  logic                               out_valid_o;
  logic                               out_stall_i = 1'b0;
  logic signed [lie_pkg::VAL_W-1:0]   interp_value_o;
  logic [lie_pkg::STATUS_W-1:0]       status_o;
  logic [lie_pkg::COUNT_W-1:0]        stored_count_o;

  lagrange_interpolation_eval dut (.*);

  cmd_t    cmd_q[$];
  answer_t answer_q[$];
  logic [CW-1:0] xs [NPTS];
  logic [CW-1:0] ys [NPTS];
  int unsigned npoints = 0;
  int  n_cmds = 0;
  int  acc_cnt = 0;
  int  drive_idx = 0;
  int  errors = 0;
  int  hold_left = 0;
  bit  held = 0;
  bit  taken = 0;
  bit  started = 0;

  cmd_t dir_tab [24] = '{
    '{lie_pkg::OP_EVAL,  0,   0,   0,   1, 0, lie_pkg::ST_EMPTY, 0},
    '{lie_pkg::OP_NOP,   799, 799, 799, 1, 0, lie_pkg::ST_OK,    0},
    '{lie_pkg::OP_ADD,   799, 799, 0,   1, 0, lie_pkg::ST_OK,    1},
    '{lie_pkg::OP_EVAL,  0,   0,   0,   1, 48'sd52363264, lie_pkg::ST_OK, 1},
    '{lie_pkg::OP_ADD,   0,   0,   0,   0, 0, lie_pkg::ST_OK,    0},
    '{lie_pkg::OP_EVAL,  0,   0,   799, 0, 0, lie_pkg::ST_OK,    0},
    '{lie_pkg::OP_EVAL,  0,   0,   400, 0, 0, lie_pkg::ST_OK,    0},
    '{lie_pkg::OP_ADD,   799, 5,   0,   1, 0, lie_pkg::ST_OK,    3},
    '{lie_pkg::OP_EVAL,  0,   0,   3,   1, 0, lie_pkg::ST_DUP,   3},
    '{lie_pkg::OP_CLEAR, 0,   0,   0,   1, 0, lie_pkg::ST_OK,    0},
    '{lie_pkg::OP_ADD,   0,   0,   0,   0, 0, lie_pkg::ST_OK,    0},
    '{lie_pkg::OP_ADD,   1,   799, 0,   0, 0, lie_pkg::ST_OK,    0},
    '{lie_pkg::OP_ADD,   2,   0,   0,   0, 0, lie_pkg::ST_OK,    0},
    '{lie_pkg::OP_ADD,   3,   799, 0,   0, 0, lie_pkg::ST_OK,    0},
    '{lie_pkg::OP_ADD,   4,   0,   0,   0, 0, lie_pkg::ST_OK,    0},
    '{lie_pkg::OP_ADD,   5,   799, 0,   0, 0, lie_pkg::ST_OK,    0},
    '{lie_pkg::OP_ADD,   6,   0,   0,   0, 0, lie_pkg::ST_OK,    0},
    '{lie_pkg::OP_ADD,   7,   799, 0,   0, 0, lie_pkg::ST_OK,    0},
    '{lie_pkg::OP_ADD,   8,   0,   0,   0, 0, lie_pkg::ST_OK,    0},
    '{lie_pkg::OP_ADD,   9,   799, 0,   0, 0, lie_pkg::ST_OK,    0},
    '{lie_pkg::OP_EVAL,  0,   0,   799, 0, 0, lie_pkg::ST_OK,    0},
    '{lie_pkg::OP_EVAL,  0,   0,   5,   0, 0, lie_pkg::ST_OK,    0},
    '{lie_pkg::OP_EVAL,  0,   0,   224, 0, 0, lie_pkg::ST_OK,    0},
    '{lie_pkg::OP_CLEAR, 0,   0,   0,   1, 0, lie_pkg::ST_OK,    0}
  };

  function automatic longint clamp48(longint v, ref bit sat);
    if (v > QMAX) begin
      sat = 1'b1;
      return QMAX;
    end
    if (v < QMIN) begin
      sat = 1'b1;
      return QMIN;
    end
    return v;
  endfunction

  function automatic answer_t predict_answer(cmd_t c);
    answer_t a;
    bit      dup;
    bit      sat;
    longint  sum;
    longint  term;
    longint  num;
    longint  den;
    a.val = '0;
    a.st = lie_pkg::ST_OK;
    dup = 1'b0;
    sat = 1'b0;
    sum = 0;
    case (c.op)
      lie_pkg::OP_ADD: begin
        if (npoints >= NPTS) a.st = lie_pkg::ST_FULL;
        else begin
          xs[npoints] = c.px;
          ys[npoints] = c.py;
          npoints++;
        end
      end
      lie_pkg::OP_EVAL: begin
        for (int i = 0; i < npoints; i++)
          for (int j = i + 1; j < npoints; j++)
            if (xs[i] == xs[j]) dup = 1'b1;
        if (npoints == 0) a.st = lie_pkg::ST_EMPTY;
        else if (dup) a.st = lie_pkg::ST_DUP;
        else begin
          for (int w = 0; w < npoints; w++) begin
            term = longint'(ys[w]) <<< lie_pkg::FRAC_W;
            for (int v = 0; v < npoints; v++) begin
              if (v != w) begin
                num = longint'(c.qx) - longint'(xs[v]);
                den = longint'(xs[w]) - longint'(xs[v]);
                term = clamp48((term * num) / den, sat);
              end
            end
            sum = clamp48(sum + term, sat);
          end
          a.val = sum[lie_pkg::VAL_W-1:0];
          if (sat) a.st = lie_pkg::ST_SAT;
        end
      end
      lie_pkg::OP_CLEAR: npoints = 0;
      default: ;
    endcase
    a.cnt = npoints[lie_pkg::COUNT_W-1:0];
    return a;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic int phase_now();
    return (acc_cnt * 4) / (n_cmds == 0 ? 1 : n_cmds);
  endfunction

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #50_000_000;
    $display("tb NOT OK");
    $finish;
  end

  // Build the stimulus list.
  initial begin
    cmd_t c;
    int   gcnt;
    int   r;
    foreach (dir_tab[i]) cmd_q.push_back(dir_tab[i]);
    c.typed = 0;
    c.val = '0;
    c.st = lie_pkg::ST_OK;
    c.cnt = '0;
    c.qx = '0;
    for (int i = 0; i < NPTS; i++) begin
      c.op = lie_pkg::OP_ADD;
      c.px = CW'(i * 12);
      c.py = CW'($urandom_range(0, 799));
      cmd_q.push_back(c);
    end
    c.px = CW'($urandom_range(0, 799));
    cmd_q.push_back(c);
    c.op = lie_pkg::OP_EVAL;
    c.qx = CW'($urandom_range(0, 799));
    cmd_q.push_back(c);
    c.op = lie_pkg::OP_CLEAR;
    cmd_q.push_back(c);
    gcnt = 0;
    for (int i = 0; i < 50; i++) begin
      r = $urandom_range(0, 99);
      c.px = CW'($urandom_range(0, 799));
      c.py = CW'($urandom_range(0, 799));
      c.qx = CW'($urandom_range(0, 799));
      if ((gcnt >= 10 && r < 30) || r >= 94) begin
        c.op = lie_pkg::OP_CLEAR;
        gcnt = 0;
      end else if (r < 55) begin
        c.op = lie_pkg::OP_ADD;
        gcnt++;
      end else if (r < 87) c.op = lie_pkg::OP_EVAL;
      else c.op = lie_pkg::OP_NOP;
      cmd_q.push_back(c);
    end
    n_cmds = cmd_q.size();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    started = 1;
    while (acc_cnt < n_cmds) @(posedge clk_i);
    while (answer_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (errors == 0) $display("tb OK");
    else $display("tb NOT OK");
    $finish;
  end

  // Sender: advance on transfer, idle per phase.
  initial begin
    int  ph;
    bit  idle;
    cmd_t c;
    forever begin
      @(negedge clk_i);
      if (started && (!in_valid_i || taken)) begin
        taken = 0;
        ph = phase_now();
        idle = (hold_left == 0) &&
               (((ph == 1) && $urandom_range(0, 99) < 76) ||
                ((ph == 3) && $urandom_range(0, 99) < 20));
        if (drive_idx < n_cmds && !idle) begin
          c = cmd_q[drive_idx];
          drive_idx++;
          opcode_i <= c.op;
          point_x_i <= c.px;
          point_y_i <= c.py;
          query_x_i <= c.qx;
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: one long hold early on, then random stalls per phase.
  initial begin
    int ph;
    forever begin
      @(negedge clk_i);
      ph = phase_now();
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (!held && acc_cnt >= 12) begin
        held = 1;
        hold_left = 300;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ((ph == 2) && $urandom_range(0, 99) < 76) ||
                       ((ph == 3) && $urandom_range(0, 99) < 20);
      end
    end
  end

  always @(posedge clk_i) begin
    answer_t a;
    answer_t e;
    cmd_t    c;
    if (in_valid_i && !in_stall_o) begin
      c = cmd_q[acc_cnt];
      a = predict_answer(c);
      if (c.typed) begin
        a.val = c.val;
        a.st = c.st;
        a.cnt = c.cnt;
      end
      answer_q.push_back(a);
      acc_cnt++;
      taken = 1;
    end
    if (out_valid_o && !out_stall_i) begin
      if (answer_q.size() == 0) begin
        report_mismatch("unexpected transfer", status_o, 0);
      end else begin
        e = answer_q.pop_front();
        if (interp_value_o !== e.val) report_mismatch("interp_value", interp_value_o, e.val);
        if (status_o !== e.st) report_mismatch("status", status_o, e.st);
        if (stored_count_o !== e.cnt) report_mismatch("stored_count", stored_count_o, e.cnt);
      end
    end
  end

endmodule
